// ----- hdl/adjm_pkg.sv -----
`default_nettype none

package adjm_pkg;

    localparam int VW  = 3;
    localparam int NVW = 4;

    typedef enum logic [2:0] {
        ACT_INSERT   = 3'd0,
        ACT_DELETE   = 3'd1,
        ACT_LIST_ALL = 3'd2,
        ACT_LIST_NBR = 3'd3,
        ACT_LIST_SRC = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        KIND_EDGE       = 2'd0,
        KIND_SOURCELESS = 2'd1,
        KIND_NONE       = 2'd2,
        KIND_RANGE      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic wr_set;
    } t_edit;

    typedef struct packed {
        logic [VW-1:0] from_vertex;
        logic [VW-1:0] to_vertex;
        t_kind         kind;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/adjm_matrix.sv -----
`default_nettype none

module adjm_matrix
    import adjm_pkg::*;
#(
    parameter int MAX_VERTICES = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire t_edit                           i_edit,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] i_wr_row,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] i_wr_col,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] i_rd_row,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] i_rd_col,
    output logic                                 o_rd_bit
);

    logic [MAX_VERTICES-1:0] r_rows [MAX_VERTICES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '{default: '0};
        end else if (i_edit.wr_en) begin
            r_rows[i_wr_row][i_wr_col] <= i_edit.wr_set;
        end
    end

    assign o_rd_bit = r_rows[i_rd_row][i_rd_col];

endmodule

`default_nettype wire

// ----- hdl/adjacency_matrix_engine_core.sv -----
// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_ready   i_action, i_first_vertex, i_second_vertex
// output    out        o_out_valid / i_out_ready o_from_vertex, o_to_vertex, o_kind, o_last
// config    in         i_cfg_wr_en              i_cfg_wr_data (num_vertices)
//
// Edits in range write the matrix when accepted; errors and listings over zero vertices pass
// through ST_FLUSH to load the output register. Full and sourceless listings scan all n*n
// matrix bits, neighbor listings the n bits of one row, one bit per cycle while not stalled,
// then flush; n is num_vertices capped at MAX_VERTICES. The single bit-read port of the matrix
// and the scan sequencer set this pace. A full output register stalls the scan when a
// further hit must move out, and holds the flush until it frees.
// Synchronous reset clears the matrix at once; num_vertices resets to 8.
`default_nettype none

module adjacency_matrix_engine_core
    import adjm_pkg::*;
#(
    parameter int MAX_VERTICES = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [2:0]     i_action,
    input  wire logic [VW-1:0]  i_first_vertex,
    input  wire logic [VW-1:0]  i_second_vertex,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [VW-1:0]       o_from_vertex,
    output logic [VW-1:0]       o_to_vertex,
    output logic [1:0]          o_kind,
    output logic                o_last,
    input  wire logic           i_cfg_wr_en,
    input  wire logic [NVW-1:0] i_cfg_wr_data
);

    localparam int IW = $clog2(MAX_VERTICES);

    t_state           r_state, n_state;
    t_action          r_mode, n_mode;
    logic [IW-1:0]    r_row, n_row;
    logic [IW-1:0]    r_col, n_col;
    logic             r_incoming, n_incoming;
    logic             r_pend_valid, n_pend_valid;
    t_result          r_pend, n_pend;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;
    logic             r_out_last, n_out_last;
    logic [NVW-1:0]   r_num_vertices;

    logic [NVW-1:0]   active_n;
    logic [NVW-1:0]   active_last;
    t_action          in_action;
    logic             in_xfer;
    logic             out_free;
    logic             first_ok;
    logic             second_ok;
    logic             row_end;
    logic             col_end;
    logic             rd_bit;
    logic             hit;
    logic             stall;
    t_edit            edit;
    t_result          entry;

    assign active_n    = (r_num_vertices > NVW'(MAX_VERTICES)) ? NVW'(MAX_VERTICES)
                                                               : r_num_vertices;
    assign active_last = active_n - 1'b1;
    assign in_action   = t_action'(i_action);
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign first_ok    = NVW'(i_first_vertex) < active_n;
    assign second_ok   = NVW'(i_second_vertex) < active_n;
    assign row_end     = NVW'(r_row) == active_last;
    assign col_end     = NVW'(r_col) == active_last;

    adjm_matrix #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_matrix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_edit   (edit),
        .i_wr_row (i_first_vertex[IW-1:0]),
        .i_wr_col (i_second_vertex[IW-1:0]),
        .i_rd_row (r_row),
        .i_rd_col (r_col),
        .o_rd_bit (rd_bit)
    );

    always_comb begin
        if (r_mode == ACT_LIST_SRC) begin
            entry = '{from_vertex: VW'(r_col), to_vertex: '0, kind: KIND_SOURCELESS};
            hit   = row_end && !(r_incoming || rd_bit);
        end else begin
            entry = '{from_vertex: VW'(r_row), to_vertex: VW'(r_col), kind: KIND_EDGE};
            hit   = rd_bit;
        end
        stall = hit && r_pend_valid && !out_free;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_row        = r_row;
        n_col        = r_col;
        n_incoming   = r_incoming;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out        = r_out;
        n_out_last   = r_out_last;
        n_out_valid  = r_out_valid && !i_out_ready;
        edit         = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (in_action)
                        ACT_INSERT, ACT_DELETE: begin
                            if (first_ok && second_ok) begin
                                edit.wr_en  = 1'b1;
                                edit.wr_set = (in_action == ACT_INSERT);
                            end else begin
                                n_pend       = '{from_vertex: '0, to_vertex: '0,
                                                 kind: KIND_RANGE};
                                n_pend_valid = 1'b1;
                                n_state      = ST_FLUSH;
                            end
                        end
                        ACT_LIST_ALL, ACT_LIST_SRC: begin
                            n_mode     = in_action;
                            n_row      = '0;
                            n_col      = '0;
                            n_incoming = 1'b0;
                            n_state    = (active_n == '0) ? ST_FLUSH : ST_SCAN;
                        end
                        ACT_LIST_NBR: begin
                            if (first_ok) begin
                                n_mode  = in_action;
                                n_row   = i_first_vertex[IW-1:0];
                                n_col   = '0;
                                n_state = ST_SCAN;
                            end else begin
                                n_pend       = '{from_vertex: '0, to_vertex: '0,
                                                 kind: KIND_RANGE};
                                n_pend_valid = 1'b1;
                                n_state      = ST_FLUSH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (hit) begin
                        if (r_pend_valid) begin
                            n_out       = r_pend;
                            n_out_last  = 1'b0;
                            n_out_valid = 1'b1;
                        end
                        n_pend       = entry;
                        n_pend_valid = 1'b1;
                    end
                    case (r_mode)
                        ACT_LIST_ALL: begin
                            if (col_end) begin
                                n_col = '0;
                                if (row_end) begin
                                    n_state = ST_FLUSH;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        ACT_LIST_NBR: begin
                            if (col_end) begin
                                n_state = ST_FLUSH;
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        default: begin
                            if (row_end) begin
                                n_row      = '0;
                                n_incoming = 1'b0;
                                if (col_end) begin
                                    n_state = ST_FLUSH;
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                            end else begin
                                n_row      = r_row + 1'b1;
                                n_incoming = r_incoming || rd_bit;
                            end
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out        = r_pend_valid ? r_pend
                                                : t_result'{from_vertex: '0, to_vertex: '0,
                                                            kind: KIND_NONE};
                    n_out_last   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_mode         <= ACT_LIST_ALL;
            r_row          <= '0;
            r_col          <= '0;
            r_incoming     <= 1'b0;
            r_pend_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
            r_num_vertices <= NVW'(8);
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_row        <= n_row;
            r_col        <= n_col;
            r_incoming   <= n_incoming;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_num_vertices <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_from_vertex = r_out.from_vertex;
    assign o_to_vertex   = r_out.to_vertex;
    assign o_kind        = r_out.kind;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

// ----- hdl/adjm_checker.sv -----
`default_nettype none

module adjm_checker
    import adjm_pkg::*;
(
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_in_ready,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire logic [VW-1:0]  o_from_vertex,
    input wire logic [VW-1:0]  o_to_vertex,
    input wire logic [1:0]     o_kind,
    input wire logic           o_last
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_from_vertex) && $stable(o_to_vertex)
            && $stable(o_kind) && $stable(o_last))
        else $error("stalled output transfer changed");

    a_single_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_NONE || o_kind == KIND_RANGE) |-> o_last)
        else $error("nothing-found or range result without last");

    a_to_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_EDGE |-> o_to_vertex == '0)
        else $error("to_vertex set on a non-edge result");

    a_busy_mid_listing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input accepted in the middle of a listing");

endmodule

bind adjacency_matrix_engine_core adjm_checker u_adjm_checker (.*);

`default_nettype wire

// ----- verif/adjm_listing_check.sv -----
`timescale 1ns / 1ps

module adjm_listing_check
    import adjm_pkg::*;
#(
    parameter int MAX_VERTICES = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  logic [2:0]     i_action,
    input  logic [VW-1:0]  i_first_vertex,
    input  logic [VW-1:0]  i_second_vertex,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  logic [VW-1:0]  i_from_vertex,
    input  logic [VW-1:0]  i_to_vertex,
    input  logic [1:0]     i_kind,
    input  logic           i_last,
    input  logic           i_cfg_wr_en,
    input  logic [NVW-1:0] i_cfg_wr_data,
    output int             o_fail_count,
    output int             o_pending
);

    typedef struct packed {
        logic [VW-1:0] from_v;
        logic [VW-1:0] to_v;
        t_kind         kind;
        logic          last;
    } t_hit;

    t_hit                    expected_hits[$];
    logic [MAX_VERTICES-1:0] adj_rows[MAX_VERTICES];
    logic [NVW-1:0]          vertex_limit = NVW'(8);
    int                      mismatches   = 0;

    function automatic int active_vertices();
        return (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_limit);
    endfunction

    function automatic t_hit make_hit(input int from_v, input int to_v, input t_kind kind);
        t_hit h;
        h.from_v = from_v[VW-1:0];
        h.to_v   = to_v[VW-1:0];
        h.kind   = kind;
        h.last   = 1'b0;
        return h;
    endfunction

    task automatic apply_graph_op(input logic [2:0] act, input logic [VW-1:0] fv,
                                  input logic [VW-1:0] sv);
        t_hit hits[$];
        t_hit tail;
        int   n;
        bit   reached;
        n = active_vertices();
        case (act)
            ACT_INSERT, ACT_DELETE: begin
                if (fv >= n || sv >= n) begin
                    hits = {hits, make_hit(0, 0, KIND_RANGE)};
                end else begin
                    adj_rows[fv][sv] = (act == ACT_INSERT);
                    return;
                end
            end
            ACT_LIST_ALL: begin
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                        if (adj_rows[i][j]) hits = {hits, make_hit(i, j, KIND_EDGE)};
            end
            ACT_LIST_NBR: begin
                if (fv >= n) begin
                    hits = {hits, make_hit(0, 0, KIND_RANGE)};
                end else begin
                    for (int j = 0; j < n; j++)
                        if (adj_rows[fv][j])
                            hits = {hits, make_hit(int'(fv), j, KIND_EDGE)};
                end
            end
            ACT_LIST_SRC: begin
                for (int j = 0; j < n; j++) begin
                    reached = 1'b0;
                    for (int i = 0; i < n; i++)
                        if (adj_rows[i][j]) reached = 1'b1;
                    if (!reached) hits = {hits, make_hit(j, 0, KIND_SOURCELESS)};
                end
            end
            default: return;
        endcase
        if (hits.size() == 0) hits = {hits, make_hit(0, 0, KIND_NONE)};
        tail = hits[hits.size() - 1];
        tail.last = 1'b1;
        hits[hits.size() - 1] = tail;
        expected_hits = {expected_hits, hits};
    endtask

    task automatic note_failure(input string what, input t_hit want, input t_hit got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: exp f=%0d t=%0d k=%0d l=%0d, got f=%0d t=%0d k=%0d l=%0d",
                     $time, what, want.from_v, want.to_v, want.kind, want.last,
                     got.from_v, got.to_v, got.kind, got.last);
    endtask

    always @(posedge i_clk) begin
        t_hit want;
        t_hit got;
        if (!i_rst_n) begin
            expected_hits.delete();
            for (int r = 0; r < MAX_VERTICES; r++) adj_rows[r] = '0;
            vertex_limit = NVW'(8);
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.from_v = i_from_vertex;
                got.to_v   = i_to_vertex;
                got.kind   = t_kind'(i_kind);
                got.last   = i_last;
                if (expected_hits.size() == 0) begin
                    note_failure("unexpected result", '0, got);
                end else begin
                    want = expected_hits.pop_front();
                    if (got.from_v !== want.from_v || got.to_v !== want.to_v ||
                        got.kind !== want.kind || got.last !== want.last)
                        note_failure("result mismatch", want, got);
                end
            end
            if (i_cfg_wr_en) vertex_limit = i_cfg_wr_data;
            if (i_in_valid && i_in_ready)
                apply_graph_op(i_action, i_first_vertex, i_second_vertex);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_hits.size();
    end

endmodule

// ----- verif/tb_adjacency_matrix_engine_core.sv -----
`timescale 1ns / 1ps

module tb_adjacency_matrix_engine_core;
    import adjm_pkg::*;

    localparam int         MAX_VERTICES  = 8;
    localparam int         DRAIN_CYCLES  = 80;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         PHASE_ITEMS   = 10;
    localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
    localparam logic [2:0] ACT_RSVD_LAST  = 3'd7;

    logic           clk           = 1'b0;
    logic           rst_n         = 1'b0;
    logic           in_valid      = 1'b0;
    logic           in_ready;
    logic [2:0]     action        = '0;
    logic [VW-1:0]  first_vertex  = '0;
    logic [VW-1:0]  second_vertex = '0;
    logic           out_valid;
    logic           out_ready     = 1'b0;
    logic [VW-1:0]  from_vertex;
    logic [VW-1:0]  to_vertex;
    logic [1:0]     kind;
    logic           last;
    logic           cfg_wr_en     = 1'b0;
    logic [NVW-1:0] cfg_wr_data   = '0;

    logic calm        = 1'b0;
    int   stall_left  = 0;
    int   idle_cycles = 0;
    int   fail_count;
    int   pending;

    int nv_plan[12] = '{15, 0, 1, 2, 9, 3, 5, 12, 8, 4, 7, 6};

    adjacency_matrix_engine_core #(
        .MAX_VERTICES(MAX_VERTICES)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_action       (action),
        .i_first_vertex (first_vertex),
        .i_second_vertex(second_vertex),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_from_vertex  (from_vertex),
        .o_to_vertex    (to_vertex),
        .o_kind         (kind),
        .o_last         (last),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data)
    );

    adjm_listing_check #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_listing_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_action       (action),
        .i_first_vertex (first_vertex),
        .i_second_vertex(second_vertex),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_from_vertex  (from_vertex),
        .i_to_vertex    (to_vertex),
        .i_kind         (kind),
        .i_last         (last),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #2 clk = ~clk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge clk) begin
        if (calm) begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready  <= 1'b1;
            stall_left <= ($urandom_range(0, 99) < 30) ? gap_length() : 0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [2:0] act, input logic [VW-1:0] fv,
                             input logic [VW-1:0] sv);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        first_vertex  <= fv;
        second_vertex <= sv;
        // hold the payload until the transfer
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_vertex_count(input int value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= NVW'(value);
        calm        <= ($urandom_range(0, 3) == 0);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [VW-1:0] pick_vertex(input int n_active);
        if (n_active == 0 || $urandom_range(0, 99) < 10)
            return VW'($urandom_range(0, (1 << VW) - 1));
        return VW'($urandom_range(0, n_active - 1));
    endfunction

    function automatic logic [2:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 38) return ACT_INSERT;
        if (r < 55) return ACT_DELETE;
        if (r < 67) return ACT_LIST_ALL;
        if (r < 82) return ACT_LIST_NBR;
        if (r < 95) return ACT_LIST_SRC;
        return 3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
    endfunction

    initial begin
        int         n_active;
        int         sent;
        logic [2:0] act;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        set_vertex_count(8);
        send_item(ACT_LIST_ALL, 3'd0, 3'd0);
        send_item(ACT_LIST_SRC, 3'd0, 3'd0);
        send_item(ACT_LIST_NBR, 3'd7, 3'd0);
        send_item(ACT_INSERT, 3'd0, 3'd7);
        send_item(ACT_INSERT, 3'd7, 3'd0);
        send_item(ACT_INSERT, 3'd3, 3'd3);
        send_item(ACT_INSERT, 3'd0, 3'd7);
        send_item(ACT_DELETE, 3'd5, 3'd5);
        for (int a = ACT_RSVD_FIRST; a <= ACT_RSVD_LAST; a++)
            send_item(3'(a), 3'd7, 3'd7);
        send_item(ACT_LIST_ALL, 3'd0, 3'd0);
        send_item(ACT_LIST_NBR, 3'd0, 3'd0);
        send_item(ACT_LIST_NBR, 3'd7, 3'd0);
        send_item(ACT_LIST_SRC, 3'd0, 3'd0);
        send_item(ACT_DELETE, 3'd7, 3'd0);
        send_item(ACT_LIST_NBR, 3'd7, 3'd0);

        // shrink the graph: upper edges stay stored but drop out of view
        set_vertex_count(4);
        send_item(ACT_INSERT, 3'd5, 3'd1);
        send_item(ACT_INSERT, 3'd1, 3'd6);
        send_item(ACT_DELETE, 3'd4, 3'd0);
        send_item(ACT_LIST_NBR, 3'd6, 3'd0);
        send_item(ACT_LIST_ALL, 3'd0, 3'd0);
        send_item(ACT_LIST_SRC, 3'd0, 3'd0);

        // fill the full matrix for the longest listing
        set_vertex_count(8);
        for (int i = 0; i < MAX_VERTICES; i++)
            for (int j = 0; j < MAX_VERTICES; j++)
                send_item(ACT_INSERT, VW'(i), VW'(j));
        send_item(ACT_LIST_ALL, 3'd0, 3'd0);
        send_item(ACT_LIST_SRC, 3'd0, 3'd0);

        foreach (nv_plan[p]) begin
            set_vertex_count(nv_plan[p]);
            n_active = (nv_plan[p] > MAX_VERTICES) ? MAX_VERTICES : nv_plan[p];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                act = pick_action();
                send_item(act, pick_vertex(n_active), pick_vertex(n_active));
                if (act < ACT_RSVD_FIRST) sent++;
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
